/* rtl/core/ppu_pkg.sv */
package ppu_pkg;

	localparam int unsigned DivSteps = 47;
	localparam logic [31:0] MinDepth = 32'd655;

	typedef enum logic [2:0] {
		REG_SCREEN_SCALE = 3'd0,
		REG_X_CENTER     = 3'd1,
		REG_Y_CENTER     = 3'd2,
		REG_DEPTH_SCALE  = 3'd3,
		REG_CLIP_LEFT    = 3'd4,
		REG_CLIP_RIGHT   = 3'd5,
		REG_CLIP_TOP     = 3'd6,
		REG_CLIP_BOTTOM  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                    vld;
		logic [1:0]              func;
		logic signed [31:0]      x;
		logic signed [31:0]      y;
		logic [31:0]             d;
		logic [31:0]             rem_q;
		logic [31:0]             rem_r;
		logic [DivSteps-1:0]     num_q;
		logic [DivSteps-1:0]     num_r;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] x_center;
		logic signed [31:0] y_center;
		logic [30:0]        depth_scale;
		logic signed [31:0] clip_left;
		logic signed [31:0] clip_right;
		logic signed [31:0] clip_top;
		logic signed [31:0] clip_bottom;
	} cfg_t;

endpackage

/* rtl/core/ppu_div_cell.sv */
module ppu_div_cell import ppu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cell_t cin,
	output cell_t cout
);

	logic [32:0] tq, tr;
	logic        bq, br;
	cell_t       nxt;

	always_comb begin
		nxt = cin;
		tq = {cin.rem_q, cin.num_q[DivSteps-1]};
		tr = {cin.rem_r, cin.num_r[DivSteps-1]};
		bq = (tq >= {1'b0, cin.d});
		br = (tr >= {1'b0, cin.d});
		nxt.rem_q = bq ? 32'(tq - {1'b0, cin.d}) : tq[31:0];
		nxt.rem_r = br ? 32'(tr - {1'b0, cin.d}) : tr[31:0];
		nxt.num_q = {cin.num_q[DivSteps-2:0], bq};
		nxt.num_r = {cin.num_r[DivSteps-2:0], br};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else if (en) begin
			cout <= nxt;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cout.vld |-> (cout.rem_q < cout.d) && (cout.rem_r < cout.d))
		else $error("remainder not below divisor");
	a_depth_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cout.vld |-> cout.d >= MinDepth)
		else $error("depth below floor");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cout))
		else $error("cell moved while stalled");

endmodule

/* rtl/core/ppu_post.sv */
module ppu_post import ppu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cell_t              cin,
	input  cfg_t               cfg,
	output logic               vld,
	output logic signed [31:0] px,
	output logic signed [31:0] py,
	output logic [30:0]        pz
);

	localparam logic signed [64:0] SatHi = 65'sd2147483647;
	localparam logic signed [64:0] SatLo = -65'sd2147483648;

	logic               vld_s1, vld_s2, vld_s3;
	logic [1:0]         func_s1, func_s2;
	logic signed [63:0] xh_s1, yh_s1;
	logic signed [48:0] xl_s1, yl_s1;
	logic [62:0]        zp_s1;
	logic [31:0]        rcp_s1;
	logic signed [64:0] sx_s2, sy_s2;
	logic [30:0]        z_s2, z_s3;
	logic signed [31:0] px_s3, py_s3;
	logic signed [64:0] cx, cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cin.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= cin.func;
			xh_s1   <= $signed(cin.x) * $signed({1'b0, cin.num_q[DivSteps-1:16]});
			yh_s1   <= $signed(cin.y) * $signed({1'b0, cin.num_q[DivSteps-1:16]});
			xl_s1   <= $signed(cin.x) * $signed({1'b0, cin.num_q[15:0]});
			yl_s1   <= $signed(cin.y) * $signed({1'b0, cin.num_q[15:0]});
			zp_s1   <= cin.d * cfg.depth_scale;
			rcp_s1  <= cin.num_r[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			sx_s2 <= 65'(cfg.x_center) + 65'(xh_s1) + 65'(xl_s1 >>> 16);
			sy_s2 <= 65'(cfg.y_center) - 65'(yh_s1) - 65'(yl_s1 >>> 16);
			if (func_s1[0]) begin
				z_s2 <= rcp_s1[30:0];
			end else if (|zp_s1[62:47]) begin
				z_s2 <= 31'h7fffffff;
			end else begin
				z_s2 <= zp_s1[46:16];
			end
		end
	end

	always_comb begin
		cx = sx_s2;
		cy = sy_s2;
		if (func_s2[1]) begin
			if (sx_s2 < 65'(cfg.clip_left)) begin
				cx = 65'(cfg.clip_left);
			end else if (sx_s2 > 65'(cfg.clip_right)) begin
				cx = 65'(cfg.clip_right);
			end
			if (sy_s2 < 65'(cfg.clip_top)) begin
				cy = 65'(cfg.clip_top);
			end else if (sy_s2 > 65'(cfg.clip_bottom)) begin
				cy = 65'(cfg.clip_bottom);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3 <= z_s2;
			if (cx > SatHi) begin
				px_s3 <= 32'sh7fffffff;
			end else if (cx < SatLo) begin
				px_s3 <= 32'sh80000000;
			end else begin
				px_s3 <= cx[31:0];
			end
			if (cy > SatHi) begin
				py_s3 <= 32'sh7fffffff;
			end else if (cy < SatLo) begin
				py_s3 <= 32'sh80000000;
			end else begin
				py_s3 <= cy[31:0];
			end
		end
	end

	assign vld = vld_s3;
	assign px  = px_s3;
	assign py  = py_s3;
	assign pz  = z_s3;

endmodule

/* rtl/core/perspective_projection_unit.sv */
// Perspective projection: one item per cycle while the output is taken, in a pipeline
// of one depth stage, a 47-cell restoring divider chain that forms the scale quotient
// and the reciprocal depth together, then three multiply/add/clamp stages. The
// whole pipeline stalls only while a result waits at the output and is not taken.
// APB registers sit at byte addresses 4*i and read back as written; scale bit 31 reads 0.
module perspective_projection_unit import ppu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] cam_x,
	input  logic signed [31:0] cam_y,
	input  logic signed [31:0] cam_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] proj_x,
	output logic signed [31:0] proj_y,
	output logic [30:0]        proj_z
);

	logic [30:0]        screen_scale_q, depth_scale_q;
	logic signed [31:0] x_center_q, y_center_q;
	logic signed [31:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
	cfg_t               cfg;
	logic               en;
	logic signed [32:0] negz;
	cell_t              front;
	cell_t              chain [0:DivSteps];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_scale_q <= 31'd65536;
			x_center_q     <= '0;
			y_center_q     <= '0;
			depth_scale_q  <= 31'd32768;
			clip_left_q    <= '0;
			clip_right_q   <= 32'sd41877504;
			clip_top_q     <= '0;
			clip_bottom_q  <= 32'sd31391744;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_SCREEN_SCALE: screen_scale_q <= pwdata[30:0];
				REG_X_CENTER:     x_center_q     <= pwdata;
				REG_Y_CENTER:     y_center_q     <= pwdata;
				REG_DEPTH_SCALE:  depth_scale_q  <= pwdata[30:0];
				REG_CLIP_LEFT:    clip_left_q    <= pwdata;
				REG_CLIP_RIGHT:   clip_right_q   <= pwdata;
				REG_CLIP_TOP:     clip_top_q     <= pwdata;
				REG_CLIP_BOTTOM:  clip_bottom_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_SCREEN_SCALE: prdata = {1'b0, screen_scale_q};
			REG_X_CENTER:     prdata = x_center_q;
			REG_Y_CENTER:     prdata = y_center_q;
			REG_DEPTH_SCALE:  prdata = {1'b0, depth_scale_q};
			REG_CLIP_LEFT:    prdata = clip_left_q;
			REG_CLIP_RIGHT:   prdata = clip_right_q;
			REG_CLIP_TOP:     prdata = clip_top_q;
			REG_CLIP_BOTTOM:  prdata = clip_bottom_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg = '{x_center: x_center_q, y_center: y_center_q, depth_scale: depth_scale_q,
		clip_left: clip_left_q, clip_right: clip_right_q, clip_top: clip_top_q,
		clip_bottom: clip_bottom_q};

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign negz = -33'(cam_z);

	always_comb begin
		front       = '0;
		front.vld   = in_valid;
		front.func  = func;
		front.x     = cam_x;
		front.y     = cam_y;
		front.d     = (negz < 33'sd655) ? MinDepth : negz[31:0];
		front.num_q = {screen_scale_q, 16'h0000};
		front.num_r = DivSteps'(64'h1_0000_0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (en) begin
			chain[0] <= front;
		end
	end

	for (genvar i = 0; i < DivSteps; i++) begin : g_cell
		ppu_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cin    (chain[i]),
			.cout   (chain[i+1])
		);
	end

	ppu_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cin    (chain[DivSteps]),
		.cfg    (cfg),
		.vld    (out_valid),
		.px     (proj_x),
		.py     (proj_y),
		.pz     (proj_z)
	);

endmodule
